// ===== src/bcp_pkg.sv =====
package bcp_pkg;

  localparam int unsigned MemBytesDef   = 2048;
  localparam int unsigned MaxObjectsDef = 64;

  localparam logic [15:0] NearDefault = 16'h6400;
  localparam logic [7:0]  AllMode     = 8'h0c;
  localparam int unsigned RecStride   = 14;

  // height fix-up pattern
  localparam logic [15:0] FixW = 16'h0058;
  localparam logic [15:0] FixD = 16'h0004;
  localparam logic [15:0] FixH = 16'h0010;
  localparam logic [15:0] FixY = 16'h0030;

  localparam logic [1:0] FuncRead  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncCtrl  = 2'd2;

  typedef enum logic [4:0] {
    StClear,
    StIdle,
    StBus,
    StOut,
    StOpRd,
    StOpWait,
    StHdrRd,
    StHdrWait,
    StRecRd,
    StRecWait,
    StRecEval,
    StRecWr,
    StPrjRd,
    StPrjWait,
    StPrjDiv,
    StPrjWr,
    StZero
  } state_e;

endpackage

// ===== src/bcp_ram.sv =====
module bcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/bcp_div.sv =====
module bcp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [23:0] num_i,
  input  logic [15:0] den_i,
  output logic        busy_o,
  output logic [15:0] quo_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic [23:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [16:0] trial;

  // restoring divider, one quotient bit a cycle
  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    if (start_i) begin
      cnt_d = 5'd24;
      quo_d = num_i;
      rem_d = '0;
    end else if (cnt_q != 5'd0) begin
      trial = {rem_q[15:0], quo_q[23]};
      quo_d = {quo_q[22:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = trial - {1'b0, den_i};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != 5'd0);
  assign quo_o  = quo_q[15:0];

endmodule

// ===== src/box_collision_projection_coproc.sv =====
// box collision and projection coprocessor
// input channel: func_i / addr_i / wdata_i under valid_i / ready_o; output
// channel: rdata_o / pass_done_o under out_valid_o / out_ready_i. one result
// per input transfer.
// a bus read with the memory window open (win 2, en set) passes through
// StBus and StOpWait before its result is valid in StOut; a write or a
// control write without a pass goes from StBus to StOut. the memory is
// shared, with one write port and a registered read port. the next input
// can be taken in the cycle after the result transfer.
// a control write with a rising start bit runs a pass over the memory:
// collision reads the header, then each record, skipping a record whose
// live byte is zero unless the mode is AllMode; projection reads the
// header, then reads, divides (serial divider) and writes back each word,
// then clears every byte after the words to the end of memory.
// after reset a clearing pass writes zero to every byte, during which
// ready_o is low.
// a result waits in the output register while out_ready_i is low; no new
// input is taken until it is transferred.
module box_collision_projection_coproc
  import bcp_pkg::*;
#(
  parameter int unsigned MemBytes   = MemBytesDef,
  parameter int unsigned MaxObjects = MaxObjectsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [1:0] func_i,
  input  logic [10:0] addr_i,
  input  logic [7:0] wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] rdata_o,
  output logic       pass_done_o
);

  localparam int unsigned AW  = $clog2(MemBytes);
  localparam int unsigned CW  = AW + 2;
  localparam int unsigned End = RecStride * MaxObjects + 2;

  state_e state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;   // byte address counter
  logic [CW-1:0] rec_q, rec_d;   // record base / projection end
  logic [4:0]    idx_q, idx_d;   // byte index within a header or record
  logic [7:0]    buf_q [14];
  logic [7:0]    buf_d [14];
  logic [15:0]   ref_q [6];
  logic [15:0]   ref_d [6];
  logic [7:0]    mode_q, mode_d;
  logic [15:0]   near_q, near_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          hit_q, hit_d;
  logic [1:0]    win_q, win_d;
  logic          en_q, en_d;
  logic          prev_q, prev_d;
  logic [1:0]    func_q, func_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [7:0]    wdat_q, wdat_d;
  logic [7:0]    rdata_q, rdata_d;
  logic          done_q, done_d;
  logic          op_col_q, op_col_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wbyte, mdata;
  logic          div_start, div_busy;
  logic [15:0]   div_quo;

  bcp_ram #(.Width(8), .Depth(MemBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wbyte),
    .raddr_i(raddr),
    .rdata_o(mdata)
  );

  bcp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({buf_q[0], buf_q[1], 8'h00}),
    .den_i  (near_q),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  // record words and overlap test
  logic [15:0] w2 [6];
  logic [16:0] dx, dz, dy, sx, sz, sy;
  logic        ovl;
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      w2[k] = {buf_q[2*k+1], buf_q[2*k+2]};
    end
    if (w2[1] == FixW && w2[3] == FixD && w2[5] == FixH && w2[4] == FixY) begin
      w2[5] = w2[4];
    end
    dx = (ref_q[0] > w2[0]) ? {1'b0, ref_q[0] - w2[0]} : {1'b0, w2[0] - ref_q[0]};
    dz = (ref_q[2] > w2[2]) ? {1'b0, ref_q[2] - w2[2]} : {1'b0, w2[2] - ref_q[2]};
    dy = (ref_q[4] > w2[4]) ? {1'b0, ref_q[4] - w2[4]} : {1'b0, w2[4] - ref_q[4]};
    sx = {1'b0, ref_q[1]} + {1'b0, w2[1]};
    sz = {1'b0, ref_q[3]} + {1'b0, w2[3]};
    sy = {1'b0, ref_q[5]} + {1'b0, w2[5]};
    ovl = (dx < sx) && (dz < sz) && (dy < sy);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    rec_d = rec_q;
    idx_d = idx_q;
    buf_d = buf_q;
    ref_d = ref_q;
    mode_d = mode_q;
    near_d = near_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    win_d = win_q;
    en_d = en_q;
    prev_d = prev_q;
    func_d = func_q;
    addr_d = addr_q;
    wdat_d = wdat_q;
    rdata_d = rdata_q;
    done_d = done_q;
    op_col_d = op_col_q;
    we = 1'b0;
    waddr = ptr_q[AW-1:0];
    wbyte = 8'h00;
    raddr = ptr_q[AW-1:0];
    div_start = 1'b0;
    ready_o = 1'b0;
    case (state_q)
      StClear: begin
        we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CW'(MemBytes - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        ready_o = 1'b1;
        if (valid_i) begin
          func_d = func_i;
          addr_d = AW'(addr_i);
          wdat_d = wdata_i;
          state_d = StBus;
        end
      end
      StBus: begin
        rdata_d = 8'h00;
        done_d = 1'b0;
        raddr = addr_q;
        state_d = StOut;
        case (func_q)
          FuncRead: begin
            if (win_q == 2'd2 && en_q) begin
              state_d = StOpWait;
              op_col_d = 1'b0;
            end
          end
          FuncWrite: begin
            if (win_q == 2'd2 && en_q) begin
              we = 1'b1;
              waddr = addr_q;
              wbyte = wdat_q;
            end
          end
          FuncCtrl: begin
            win_d = wdat_q[5:4];
            en_d = wdat_q[7];
            prev_d = wdat_q[6];
            if (wdat_q[6] && !prev_q) begin
              done_d = 1'b1;
              ptr_d = CW'(2);
              state_d = StOpRd;
            end
          end
          default: ;
        endcase
        if (func_q == FuncRead && win_q == 2'd2 && en_q) begin
          state_d = StOpWait;
          op_col_d = 1'b1;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      StOpRd: begin
        ptr_d = '0;
        idx_d = '0;
        op_col_d = 1'b0;
        state_d = StOpWait;
      end
      StOpWait: begin
        if (op_col_q) begin
          // bus read data
          rdata_d = mdata;
          state_d = StOut;
        end else if (mdata == 8'd1) begin
          ptr_d = CW'(1);
          idx_d = '0;
          state_d = StHdrRd;
        end else if (mdata > 8'd1) begin
          ptr_d = CW'(0);
          idx_d = '0;
          state_d = StHdrRd;
          op_col_d = 1'b1;
        end else begin
          state_d = StOut;
        end
      end
      // header: collision reads bytes 1..14, projection bytes 0..3
      StHdrRd: begin
        ptr_d = ptr_q + 1'b1;
        state_d = StHdrWait;
      end
      StHdrWait: begin
        buf_d[idx_q[3:0]] = mdata;
        idx_d = idx_q + 1'b1;
        if (!op_col_q && idx_q == 5'd13) begin
          mode_d = buf_q[0];
          for (int k = 0; k < 6; k++) begin
            ref_d[k] = {buf_q[2*k+2], (2*k+3 == 13) ? mdata : buf_q[2*k+3]};
          end
          ref_d[5] = {buf_q[12], mdata};
          rec_d = CW'(16);
          ptr_d = CW'(16);
          idx_d = '0;
          state_d = StRecRd;
        end else if (op_col_q && idx_q == 5'd3) begin
          cnt_d = {buf_q[0], buf_q[1]};
          if ({buf_q[0], buf_q[1]} > 16'(MaxObjects)) begin
            cnt_d = 16'(MaxObjects);
          end
          near_d = ({buf_q[2], mdata} == 16'h0) ? NearDefault : {buf_q[2], mdata};
          ptr_d = CW'(4);
          rec_d = CW'(4);
          state_d = StPrjRd;
        end else begin
          state_d = StHdrRd;
        end
      end
      // record: live byte then twelve word bytes
      StRecRd: begin
        if (rec_q >= CW'(End)) begin
          state_d = StOut;
        end else begin
          ptr_d = ptr_q + 1'b1;
          state_d = StRecWait;
        end
      end
      StRecWait: begin
        buf_d[idx_q[3:0]] = mdata;
        idx_d = idx_q + 1'b1;
        if (idx_q == 5'd0 && mdata == 8'h00 && mode_q != AllMode) begin
          rec_d = rec_q + CW'(RecStride);
          ptr_d = rec_q + CW'(RecStride);
          idx_d = '0;
          state_d = StRecRd;
        end else if (idx_q == 5'd12) begin
          state_d = StRecEval;
        end else begin
          state_d = StRecRd;
          if (rec_q >= CW'(End)) state_d = StOut;
        end
      end
      StRecEval: begin
        hit_d = ovl;
        if (ovl) begin
          we = 1'b1;
          waddr = AW'(15);
          wbyte = 8'h00;
        end
        state_d = StRecWr;
      end
      StRecWr: begin
        we = 1'b1;
        waddr = AW'(rec_q + CW'(13));
        wbyte = hit_q ? 8'h00 : 8'h01;
        rec_d = rec_q + CW'(RecStride);
        ptr_d = rec_q + CW'(RecStride);
        idx_d = '0;
        state_d = StRecRd;
      end
      // projection: read word, divide, write back
      StPrjRd: begin
        if (cnt_q == 16'd0) begin
          ptr_d = rec_q;
          state_d = StZero;
        end else begin
          ptr_d = ptr_q + 1'b1;
          idx_d = '0;
          state_d = StPrjWait;
        end
      end
      StPrjWait: begin
        buf_d[idx_q[3:0]] = mdata;
        idx_d = idx_q + 1'b1;
        if (idx_q == 5'd1) begin
          state_d = StPrjDiv;
          div_start = 1'b0;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      StPrjDiv: begin
        if (idx_q == 5'd2) begin
          div_start = 1'b1;
          idx_d = 5'd3;
        end else if (!div_busy) begin
          state_d = StPrjWr;
          idx_d = '0;
        end
      end
      StPrjWr: begin
        we = 1'b1;
        if (idx_q == 5'd0) begin
          waddr = AW'(rec_q);
          wbyte = div_quo[15:8];
          idx_d = 5'd1;
        end else begin
          waddr = AW'(rec_q + 1'b1);
          wbyte = div_quo[7:0];
          rec_d = rec_q + CW'(2);
          ptr_d = rec_q + CW'(2);
          cnt_d = cnt_q - 16'd1;
          state_d = StPrjRd;
        end
      end
      StZero: begin
        if (ptr_q >= CW'(MemBytes)) begin
          state_d = StOut;
        end else begin
          we = 1'b1;
          wbyte = 8'h00;
          ptr_d = ptr_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ptr_q <= '0;
      win_q <= '0;
      en_q <= 1'b0;
      prev_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      win_q <= win_d;
      en_q <= en_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    idx_q <= idx_d;
    buf_q <= buf_d;
    ref_q <= ref_d;
    mode_q <= mode_d;
    near_q <= near_d;
    cnt_q <= cnt_d;
    hit_q <= hit_d;
    func_q <= func_d;
    addr_q <= addr_d;
    wdat_q <= wdat_d;
    rdata_q <= rdata_d;
    done_q <= done_d;
    op_col_q <= op_col_d;
  end

  assign out_valid_o = (state_q == StOut);
  assign rdata_o = rdata_q;
  assign pass_done_o = done_q;

endmodule

// ===== src/bcp_checker.sv =====
module bcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] rdata_o,
  input logic       pass_done_o
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rdata_o) && $stable(pass_done_o))
    else $error("result changed while stalled");

  // never accept input while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_o && out_valid_o))
    else $error("input ready with pending result");

  // a result never both reads and runs a pass
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pass_done_o |-> rdata_o == 8'h00)
    else $error("pass result with read data");

  // an accepted transfer yields no result in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind box_collision_projection_coproc bcp_checker u_bcp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (valid_i),
  .ready_o    (ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .rdata_o    (rdata_o),
  .pass_done_o(pass_done_o)
);
